/* rtl/cbra_pkg.sv */
package cbra_pkg;

   localparam int KIND_W   = 2;
   localparam int SPACE_W  = 18;
   localparam int STATUS_W = 2;
   localparam int BUF_W    = 5;
   localparam int CNT_W    = 9;
   localparam int ADDR_W   = 3;
   localparam int DATA_W   = 32;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [SPACE_W-1:0] BYTE_LIMIT_RESET  = SPACE_W'(8192 * 16 + 128);
   localparam logic [CNT_W-1:0]   INSTR_LIMIT_RESET = CNT_W'(256);

   // register select is paddr[2]
   localparam logic REG_BYTE_LIMIT  = 1'b0;
   localparam logic REG_INSTR_LIMIT = 1'b1;

   typedef enum logic [KIND_W-1:0] {
      KIND_ALLOC = 2'd0,
      KIND_FLUSH = 2'd1,
      KIND_START = 2'd2,
      KIND_GET   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      OP_ALLOC   = 3'd0,
      OP_FLUSH   = 3'd1,
      OP_START   = 3'd2,
      OP_GET     = 3'd3,
      OP_TOO_BIG = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BUSY      = 2'd1,
      STATUS_TOO_LARGE = 2'd2,
      STATUS_DRAINED   = 2'd3
   } status_type;

   typedef struct packed {
      op_type               op;
      logic [SPACE_W-1:0]   space;
   } item_type;

   typedef struct packed {
      logic     push;
      item_type item;
   } push_type;

   typedef struct packed {
      logic     empty;
      item_type item;
   } q_out_type;

endpackage

/* rtl/cbra_front.sv */
module cbra_front import cbra_pkg::*; (
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [SPACE_W-1:0]  req_space,
   input  logic [SPACE_W-1:0]  byte_limit,
   input  logic                q_full,
   output push_type            push_o
);

   op_type op;

   // classify; an oversized allocate is settled here and needs no buffer state
   always_comb begin
      case (kind_type'(req_kind))
         KIND_ALLOC: begin
            op = (req_space > byte_limit) ? OP_TOO_BIG : OP_ALLOC;
         end
         KIND_FLUSH: begin
            op = OP_FLUSH;
         end
         KIND_START: begin
            op = OP_START;
         end
         KIND_GET: begin
            op = OP_GET;
         end
         default: begin
            op = OP_GET;
         end
      endcase
   end

   assign req_ready         = !q_full;
   assign push_o.push       = req_valid && !q_full;
   assign push_o.item.op    = op;
   assign push_o.item.space = req_space;

endmodule

/* rtl/cbra_queue.sv */
module cbra_queue import cbra_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  push_type  push_i,
   output logic      q_full,
   input  logic      q_pop,
   output q_out_type q_o
);

   item_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;
   logic               do_pop;

   localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);

   assign q_full   = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_o.empty = (cnt_ff == '0);
   assign q_o.item  = entry_ff[rd_ptr_ff];
   assign do_pop    = q_pop && !q_o.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_i.push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_i.push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !push_i.push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_i.push) begin
         entry_ff[wr_ptr_ff] <= push_i.item;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count above depth");

   assert property (@(posedge clock) disable iff (reset)
      (push_i.push && !do_pop) |=> !q_o.empty)
      else $error("queue empty after a push");

   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers differ while empty");

endmodule

/* rtl/cbra_back.sv */
module cbra_back import cbra_pkg::*; #(
   parameter int NUM_BUFS   = 32,
   parameter int MAX_SLICES = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [SPACE_W-1:0]   byte_limit,
   input  logic [CNT_W-1:0]     instr_limit,
   input  q_out_type            q_i,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [BUF_W-1:0]     rsp_buf_index,
   output logic [SPACE_W-1:0]   rsp_slice_offset,
   output logic [SPACE_W-1:0]   rsp_slice_size,
   output logic                 rsp_queue_empty,
   output logic                 rsp_nothing_flushed
);

   localparam int PTR_W  = $clog2(NUM_BUFS);
   localparam int SLOT_W = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
   localparam int DEPTH  = NUM_BUFS * MAX_SLICES;
   localparam int MEM_W  = $clog2(DEPTH);

   localparam logic [PTR_W-1:0] LAST_BUF = PTR_W'(NUM_BUFS - 1);
   localparam logic [MEM_W-1:0] SLICES_A = MEM_W'(MAX_SLICES);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type              st_ff, st_in;
   item_type               item_ff;

   logic [PTR_W-1:0]       head_ff, head_in;
   logic [PTR_W-1:0]       tail_ff, tail_in;
   logic                   pend_ff, pend_in;
   logic [SPACE_W-1:0]     fill_ff, fill_in;
   logic [CNT_W-1:0]       hcnt_ff, hcnt_in;
   logic [CNT_W-1:0]       rslot_ff, rslot_in;
   logic [SPACE_W-1:0]     roff_ff, roff_in;
   logic [NUM_BUFS-1:0]    full_ff, full_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, status_v;
   logic [BUF_W-1:0]       rsp_buf_ff;
   logic [SPACE_W-1:0]     rsp_offs_ff, offs_v;
   logic [SPACE_W-1:0]     rsp_size_ff, size_v;
   logic                   rsp_qe_ff, qe_v;
   logic                   rsp_nf_ff, nf_v;
   logic [PTR_W-1:0]       buf_v;

   logic [SPACE_W-1:0]     size_mem [DEPTH];
   logic [SPACE_W-1:0]     size_rd_ff;
   logic [CNT_W-1:0]       cnt_mem [NUM_BUFS];
   logic [CNT_W-1:0]       cnt_rd_ff;

   logic                   commit;
   logic [PTR_W-1:0]       nh, nt;
   logic [SPACE_W-1:0]     eff_fill;
   logic [CNT_W-1:0]       eff_cnt;
   logic [CNT_W-1:0]       lim;
   logic [SPACE_W:0]       sum;
   logic                   head_ok;
   logic                   need_push;
   logic                   size_we, cnt_we;
   logic [PTR_W-1:0]       wr_buf;
   logic [CNT_W-1:0]       wr_slot;
   logic [MEM_W-1:0]       rd_addr, wr_addr;

   assign q_pop  = (st_ff == ST_IDLE) && !q_i.empty;
   assign commit = (st_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);

   assign nh = (head_ff == LAST_BUF) ? '0 : head_ff + 1'b1;
   assign nt = (tail_ff == LAST_BUF) ? '0 : tail_ff + 1'b1;

   assign rd_addr = MEM_W'(tail_ff) * SLICES_A + MEM_W'(SLOT_W'(rslot_ff));
   assign wr_addr = MEM_W'(wr_buf) * SLICES_A + MEM_W'(SLOT_W'(wr_slot));

   // a zero limit acts as one; clip at the per-buffer slot count
   always_comb begin
      if (instr_limit == '0) begin
         lim = CNT_W'(1);
      end else if (int'(instr_limit) > MAX_SLICES) begin
         lim = CNT_W'(MAX_SLICES);
      end else begin
         lim = instr_limit;
      end
   end

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: begin
            if (!q_i.empty) begin
               st_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (commit) begin
               st_in = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   // a pending head buffer reads as empty once the consumer has freed it
   assign eff_fill  = pend_ff ? '0 : fill_ff;
   assign eff_cnt   = pend_ff ? '0 : hcnt_ff;
   assign head_ok   = !pend_ff || !full_ff[head_ff];
   assign sum       = {1'b0, eff_fill} + {1'b0, item_ff.space};
   assign need_push = ((sum > {1'b0, byte_limit}) || (eff_cnt >= lim)) && (eff_cnt != '0);

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      pend_in  = pend_ff;
      fill_in  = fill_ff;
      hcnt_in  = hcnt_ff;
      rslot_in = rslot_ff;
      roff_in  = roff_ff;
      full_in  = full_ff;
      status_v = STATUS_OK;
      buf_v    = head_ff;
      offs_v   = '0;
      size_v   = '0;
      size_we  = 1'b0;
      cnt_we   = 1'b0;
      wr_buf   = head_ff;
      wr_slot  = eff_cnt;
      case (item_ff.op)
         OP_TOO_BIG: begin
            status_v = STATUS_TOO_LARGE;
         end
         OP_ALLOC: begin
            if (!head_ok) begin
               status_v = STATUS_BUSY;
            end else begin
               pend_in = 1'b0;
               fill_in = eff_fill;
               hcnt_in = eff_cnt;
               if (need_push) begin
                  full_in[head_ff] = 1'b1;
                  cnt_we           = 1'b1;
                  head_in          = nh;
                  buf_v            = nh;
                  if (full_ff[nh]) begin
                     // new head is the unread tail: keep its count
                     pend_in  = 1'b1;
                     hcnt_in  = cnt_rd_ff;
                     status_v = STATUS_BUSY;
                  end else begin
                     size_v  = item_ff.space;
                     fill_in = item_ff.space;
                     hcnt_in = CNT_W'(1);
                     size_we = 1'b1;
                     wr_buf  = nh;
                     wr_slot = '0;
                  end
               end else begin
                  offs_v  = eff_fill;
                  size_v  = item_ff.space;
                  fill_in = sum[SPACE_W-1:0];
                  hcnt_in = eff_cnt + CNT_W'(1);
                  size_we = 1'b1;
               end
            end
         end
         OP_FLUSH: begin
            if (!head_ok) begin
               status_v = STATUS_BUSY;
            end else begin
               pend_in = 1'b0;
               fill_in = eff_fill;
               hcnt_in = eff_cnt;
               if (eff_cnt != '0) begin
                  full_in[head_ff] = 1'b1;
                  cnt_we           = 1'b1;
                  head_in          = nh;
                  if (full_ff[nh]) begin
                     pend_in  = 1'b1;
                     hcnt_in  = cnt_rd_ff;
                     status_v = STATUS_BUSY;
                  end else begin
                     fill_in = '0;
                     hcnt_in = '0;
                  end
               end
            end
         end
         OP_START: begin
            buf_v = tail_ff;
            if (!full_ff[tail_ff]) begin
               status_v = STATUS_BUSY;
            end else begin
               rslot_in = '0;
               roff_in  = '0;
            end
         end
         OP_GET: begin
            buf_v = tail_ff;
            if (!full_ff[tail_ff]) begin
               status_v = STATUS_BUSY;
            end else if (rslot_ff >= cnt_rd_ff) begin
               // past the last slice: free the buffer
               full_in[tail_ff] = 1'b0;
               tail_in          = nt;
               rslot_in         = '0;
               roff_in          = '0;
               status_v         = STATUS_DRAINED;
            end else begin
               size_v   = size_rd_ff;
               offs_v   = roff_ff;
               roff_in  = roff_ff + size_rd_ff;
               rslot_in = rslot_ff + CNT_W'(1);
            end
         end
         default: begin
            status_v = STATUS_OK;
         end
      endcase
      nf_v = (head_in == tail_in);
      qe_v = (head_in == tail_in) && (hcnt_in == '0);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         pend_ff      <= 1'b0;
         fill_ff      <= '0;
         hcnt_ff      <= '0;
         rslot_ff     <= '0;
         roff_ff      <= '0;
         full_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
         if (commit) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            pend_ff  <= pend_in;
            fill_ff  <= fill_in;
            hcnt_ff  <= hcnt_in;
            rslot_ff <= rslot_in;
            roff_ff  <= roff_in;
            full_ff  <= full_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         item_ff <= q_i.item;
      end
      if (commit) begin
         rsp_status_ff <= status_v;
         rsp_buf_ff    <= BUF_W'(buf_v);
         rsp_offs_ff   <= offs_v;
         rsp_size_ff   <= size_v;
         rsp_qe_ff     <= qe_v;
         rsp_nf_ff     <= nf_v;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         size_rd_ff <= size_mem[rd_addr];
      end
      if (commit && size_we) begin
         size_mem[wr_addr] <= item_ff.space;
      end
   end

   // slice count of each buffer as handed to the consumer
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cnt_rd_ff <= cnt_mem[tail_ff];
      end
      if (commit && cnt_we) begin
         cnt_mem[head_ff] <= eff_cnt;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_buf_index       = rsp_buf_ff;
   assign rsp_slice_offset    = rsp_offs_ff;
   assign rsp_slice_size      = rsp_size_ff;
   assign rsp_queue_empty     = rsp_qe_ff;
   assign rsp_nothing_flushed = rsp_nf_ff;

   assert property (@(posedge clock) disable iff (reset)
      !$stable(tail_ff) |-> $past(commit && (item_ff.op == OP_GET)))
      else $error("tail moved outside a consumer get");

   assert property (@(posedge clock) disable iff (reset)
      !$stable(head_ff) |->
         $past(commit && ((item_ff.op == OP_ALLOC) || (item_ff.op == OP_FLUSH))))
      else $error("head moved outside a producer request");

   assert property (@(posedge clock) disable iff (reset)
      $rose(pend_ff) |-> (head_ff == tail_ff))
      else $error("head parked on a full buffer that is not the tail");

   assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff)
      else $error("committed request produced no response");

endmodule

/* rtl/command_buffer_ring_allocator.sv */
// Ring of NUM_BUFS command buffers shared by one producer and one consumer.
// Producer requests allocate byte slices or flush the head buffer; consumer
// requests wait for the tail buffer to fill and then fetch its slices in order,
// one extra get freeing the buffer. Where software would block, the response
// carries a busy status and the caller retries. A two-entry queue sits between
// request decode and execution, and responses leave from an output register.
// Each request is popped into the execution unit, which registers its reads of
// the slice-size and per-buffer count memories, and is then computed and written
// back once the response register is free; no new request is popped
// until the last one has committed. Slice sizes and the per-buffer counts are
// only read after being written, so there is no clearing pass after reset.
// Limits are written through the APB port at address 0 (byte limit) and 4
// (slice limit) by the user only while the block is idle; it is not enforced.
module command_buffer_ring_allocator import cbra_pkg::*; #(
   parameter int NUM_BUFS   = 32,
   parameter int MAX_SLICES = 256
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [KIND_W-1:0]    req_kind,
   input  logic [SPACE_W-1:0]   req_space,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic [BUF_W-1:0]     rsp_buf_index,
   output logic [SPACE_W-1:0]   rsp_slice_offset,
   output logic [SPACE_W-1:0]   rsp_slice_size,
   output logic                 rsp_queue_empty,
   output logic                 rsp_nothing_flushed,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_W-1:0]    paddr,
   input  logic [DATA_W-1:0]    pwdata,
   output logic [DATA_W-1:0]    prdata,
   output logic                 pready
);

   logic [SPACE_W-1:0] byte_limit_ff;
   logic [CNT_W-1:0]   instr_limit_ff;
   logic               csr_wr;
   push_type           push;
   logic               q_full;
   logic               q_pop;
   q_out_type          q_out;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_limit_ff  <= BYTE_LIMIT_RESET;
         instr_limit_ff <= INSTR_LIMIT_RESET;
      end else if (csr_wr) begin
         if (paddr[2] == REG_BYTE_LIMIT) begin
            byte_limit_ff <= pwdata[SPACE_W-1:0];
         end else begin
            instr_limit_ff <= pwdata[CNT_W-1:0];
         end
      end
   end

   assign prdata = (paddr[2] == REG_INSTR_LIMIT) ? DATA_W'(instr_limit_ff)
                                                : DATA_W'(byte_limit_ff);

   cbra_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_kind   (req_kind),
      .req_space  (req_space),
      .byte_limit (byte_limit_ff),
      .q_full     (q_full),
      .push_o     (push)
   );

   cbra_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push_i (push),
      .q_full (q_full),
      .q_pop  (q_pop),
      .q_o    (q_out)
   );

   cbra_back #(
      .NUM_BUFS   (NUM_BUFS),
      .MAX_SLICES (MAX_SLICES)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .byte_limit          (byte_limit_ff),
      .instr_limit         (instr_limit_ff),
      .q_i                 (q_out),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_buf_index       (rsp_buf_index),
      .rsp_slice_offset    (rsp_slice_offset),
      .rsp_slice_size      (rsp_slice_size),
      .rsp_queue_empty     (rsp_queue_empty),
      .rsp_nothing_flushed (rsp_nothing_flushed)
   );

endmodule

/* tb/tb_command_buffer_ring_allocator.sv */
import cbra_pkg::*;

typedef struct {
   logic [STATUS_W-1:0] status;
   logic [BUF_W-1:0]    buf_idx;
   logic [SPACE_W-1:0]  offset;
   logic [SPACE_W-1:0]  slice_size;
   logic                queue_empty;
   logic                nothing_flushed;
} ring_reply_type;

class ring_ledger;
   logic [SPACE_W-1:0] byte_lim;
   logic [CNT_W-1:0]   instr_lim;

   logic [SPACE_W-1:0] size_store [0:8191];
   logic [SPACE_W-1:0] fill_bytes [0:31];
   logic [CNT_W-1:0]   slice_count [0:31];
   bit                 full_flags [0:31];
   logic [BUF_W-1:0]   head_ptr;
   logic [BUF_W-1:0]   tail_ptr;
   logic [CNT_W-1:0]   read_slot;
   logic [SPACE_W-1:0] read_offset;
   bit                 head_clear_pending;

   ring_reply_type owed[$];
   int errors;
   int requests;
   int replies;
   int status_seen [0:3];

   function new();
      byte_lim = BYTE_LIMIT_RESET;
      instr_lim = INSTR_LIMIT_RESET;
      foreach (size_store[i]) size_store[i] = '0;
      foreach (fill_bytes[i]) begin
         fill_bytes[i] = '0;
         slice_count[i] = '0;
         full_flags[i] = 1'b0;
      end
      head_ptr = '0;
      tail_ptr = '0;
      read_slot = '0;
      read_offset = '0;
      head_clear_pending = 1'b0;
      errors = 0;
      requests = 0;
      replies = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
   endfunction

   // clear the head buffer once the consumer has freed it; 0 means busy
   function bit settle_head();
      if (!head_clear_pending) return 1'b1;
      if (full_flags[head_ptr]) return 1'b0;
      fill_bytes[head_ptr] = '0;
      slice_count[head_ptr] = '0;
      head_clear_pending = 1'b0;
      return 1'b1;
   endfunction

   function bit push_head();
      full_flags[head_ptr] = 1'b1;
      head_ptr = head_ptr + 1'b1;
      head_clear_pending = 1'b1;
      return settle_head();
   endfunction

   function void note_request(kind_type kind, logic [SPACE_W-1:0] space);
      ring_reply_type r;
      logic [SPACE_W:0] total;
      logic [CNT_W-1:0] cap;
      bit ok;
      r.status = STATUS_OK;
      r.buf_idx = '0;
      r.offset = '0;
      r.slice_size = '0;
      cap = (instr_lim == 0) ? CNT_W'(1) : ((instr_lim > 256) ? CNT_W'(256) : instr_lim);
      case (kind)
         KIND_ALLOC: begin
            r.buf_idx = head_ptr;
            if (space > byte_lim) begin
               r.status = STATUS_TOO_LARGE;
            end else if (!settle_head()) begin
               r.status = STATUS_BUSY;
            end else begin
               ok = 1'b1;
               total = {1'b0, fill_bytes[head_ptr]} + space;
               if ((total > byte_lim || slice_count[head_ptr] >= cap) &&
                   slice_count[head_ptr] != 0)
                  ok = push_head();
               r.buf_idx = head_ptr;
               if (!ok) begin
                  r.status = STATUS_BUSY;
               end else begin
                  r.offset = fill_bytes[head_ptr];
                  r.slice_size = space;
                  size_store[{head_ptr, slice_count[head_ptr][7:0]}] = space;
                  fill_bytes[head_ptr] = fill_bytes[head_ptr] + space;
                  slice_count[head_ptr] = slice_count[head_ptr] + 1'b1;
               end
            end
         end
         KIND_FLUSH: begin
            r.buf_idx = head_ptr;
            if (!settle_head())
               r.status = STATUS_BUSY;
            else if (slice_count[head_ptr] != 0 && !push_head())
               r.status = STATUS_BUSY;
         end
         KIND_START: begin
            r.buf_idx = tail_ptr;
            if (!full_flags[tail_ptr]) begin
               r.status = STATUS_BUSY;
            end else begin
               read_slot = '0;
               read_offset = '0;
            end
         end
         default: begin
            r.buf_idx = tail_ptr;
            if (!full_flags[tail_ptr]) begin
               r.status = STATUS_BUSY;
            end else if (read_slot >= slice_count[tail_ptr]) begin
               // free the drained buffer and advance the tail
               full_flags[tail_ptr] = 1'b0;
               tail_ptr = tail_ptr + 1'b1;
               read_slot = '0;
               read_offset = '0;
               r.status = STATUS_DRAINED;
            end else begin
               r.slice_size = size_store[{tail_ptr, read_slot[7:0]}];
               r.offset = read_offset;
               read_offset = read_offset + r.slice_size;
               read_slot = read_slot + 1'b1;
            end
         end
      endcase
      r.nothing_flushed = (head_ptr == tail_ptr);
      r.queue_empty = (head_ptr == tail_ptr) && (slice_count[head_ptr] == 0);
      owed.push_back(r);
      requests++;
   endfunction

   function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   function void check_reply(ring_reply_type got);
      ring_reply_type want;
      replies++;
      if (owed.size() == 0) begin
         $display("%0t: response with no request pending: status %0d buf %0d",
                  $time, got.status, got.buf_idx);
         errors++;
         return;
      end
      want = owed.pop_front();
      status_seen[want.status]++;
      cmp_field("status", want.status, got.status);
      cmp_field("buf_index", want.buf_idx, got.buf_idx);
      cmp_field("slice_offset", want.offset, got.offset);
      cmp_field("slice_size", want.slice_size, got.slice_size);
      cmp_field("queue_empty", want.queue_empty, got.queue_empty);
      cmp_field("nothing_flushed", want.nothing_flushed, got.nothing_flushed);
   endfunction
endclass

module tb_command_buffer_ring_allocator;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [KIND_W-1:0]   req_kind = '0;
   logic [SPACE_W-1:0]  req_space = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [BUF_W-1:0]    rsp_buf_index;
   logic [SPACE_W-1:0]  rsp_slice_offset;
   logic [SPACE_W-1:0]  rsp_slice_size;
   logic                rsp_queue_empty;
   logic                rsp_nothing_flushed;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [ADDR_W-1:0]   paddr = '0;
   logic [DATA_W-1:0]   pwdata = '0;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   ring_ledger ledger = new();
   bit quiet = 1'b0;
   int sent = 0;
   int settings_used = 0;

   command_buffer_ring_allocator i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_space           (req_space),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_buf_index       (rsp_buf_index),
      .rsp_slice_offset    (rsp_slice_offset),
      .rsp_slice_size      (rsp_slice_size),
      .rsp_queue_empty     (rsp_queue_empty),
      .rsp_nothing_flushed (rsp_nothing_flushed),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   always #10 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 8);
   end

   always @(posedge clock) begin
      ring_reply_type got;
      if (!reset) begin
         if (req_valid && req_ready)
            ledger.note_request(kind_type'(req_kind), req_space);
         if (rsp_valid && rsp_ready) begin
            got.status = rsp_status;
            got.buf_idx = rsp_buf_index;
            got.offset = rsp_slice_offset;
            got.slice_size = rsp_slice_size;
            got.queue_empty = rsp_queue_empty;
            got.nothing_flushed = rsp_nothing_flushed;
            ledger.check_reply(got);
         end
      end
   end

   // entered and left at a falling edge; valid stays high for the next request
   task automatic send_request(kind_type kind, logic [SPACE_W-1:0] space);
      while (!quiet && $urandom_range(99) < 8) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_space <= space;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      sent++;
   endtask

   // hold requests until every response is back, then let the pipeline settle
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (ledger.owed.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic csr_write(logic regsel, logic [DATA_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {regsel, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      if (regsel == REG_BYTE_LIMIT)
         ledger.byte_lim = value[SPACE_W-1:0];
      else
         ledger.instr_lim = value[CNT_W-1:0];
      @(negedge clock);
   endtask

   task automatic set_limits(logic [SPACE_W-1:0] bytes, logic [CNT_W-1:0] slices);
      wait_drain();
      csr_write(REG_BYTE_LIMIT, DATA_W'(bytes));
      csr_write(REG_INSTR_LIMIT, DATA_W'(slices));
      settings_used++;
   endtask

   function automatic logic [SPACE_W-1:0] pick_space(logic [SPACE_W-1:0] lim);
      int unsigned r;
      r = $urandom_range(99);
      if (r < 55)
         return SPACE_W'($urandom_range(0, lim / 4));
      else if (r < 75)
         return SPACE_W'($urandom_range(0, lim));
      else if (r < 85)
         return $urandom_range(1) ? lim : '0;
      else if (r < 95 && lim != '1)
         return SPACE_W'($urandom_range(int'(lim) + 1, 262143));
      return SPACE_W'($urandom);
   endfunction

   task automatic random_phase(int quota);
      int stop_at;
      int n;
      int r;
      stop_at = sent + quota;
      while (sent < stop_at) begin
         r = $urandom_range(99);
         if (r < 3) begin
            wait_drain();
         end else if (r < 40) begin
            n = $urandom_range(1, 6);
            repeat (n) send_request(KIND_ALLOC, pick_space(ledger.byte_lim));
            if ($urandom_range(99) < 60) send_request(KIND_FLUSH, pick_space(ledger.byte_lim));
         end else if (r < 70) begin
            send_request(KIND_START, SPACE_W'($urandom));
            n = $urandom_range(1, 8);
            repeat (n) send_request(KIND_GET, SPACE_W'($urandom));
         end else if (r < 80) begin
            // pack the ring with one-slice buffers to reach the full ring
            n = $urandom_range(8, 34);
            repeat (n) begin
               send_request(KIND_ALLOC, pick_space(ledger.byte_lim));
               send_request(KIND_FLUSH, SPACE_W'($urandom));
            end
         end else if (r < 90) begin
            send_request(KIND_START, SPACE_W'($urandom));
            n = $urandom_range(4, 20);
            repeat (n) send_request(KIND_GET, SPACE_W'($urandom));
         end else begin
            n = $urandom_range(1, 4);
            repeat (n) send_request(kind_type'($urandom_range(3)), SPACE_W'($urandom));
         end
      end
   endtask

   initial begin
      #2000000;
      $display("%0t: timeout with %0d responses outstanding", $time, ledger.owed.size());
      $display("tb_command_buffer_ring_allocator: FAIL");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // consumer before data, empty flush, too large, auto flush on bytes, drain
      send_request(KIND_GET, '0);
      send_request(KIND_START, '1);
      send_request(KIND_FLUSH, '0);
      send_request(KIND_ALLOC, '1);
      send_request(KIND_ALLOC, BYTE_LIMIT_RESET + 1'b1);
      send_request(KIND_ALLOC, '0);
      send_request(KIND_ALLOC, BYTE_LIMIT_RESET);
      send_request(KIND_ALLOC, SPACE_W'(1));
      send_request(KIND_START, '0);
      send_request(KIND_GET, '0);
      send_request(KIND_GET, '0);
      send_request(KIND_GET, '0);
      send_request(KIND_GET, '0);
      send_request(KIND_FLUSH, '0);
      send_request(KIND_START, '0);
      send_request(KIND_GET, '0);
      send_request(KIND_GET, '0);
      send_request(KIND_ALLOC, SPACE_W'('h15555));

      // slice limit of zero behaves as one
      set_limits('1, '0);
      send_request(KIND_ALLOC, '1);
      send_request(KIND_ALLOC, '0);
      send_request(KIND_FLUSH, '0);
      send_request(KIND_START, '0);
      send_request(KIND_GET, '0);
      send_request(KIND_GET, '0);
      send_request(KIND_START, '0);
      send_request(KIND_GET, '0);
      send_request(KIND_GET, '0);

      set_limits(SPACE_W'(1000), CNT_W'(4));
      random_phase(115);
      set_limits(SPACE_W'(1), CNT_W'(1));
      random_phase(115);
      set_limits('1, '1);
      quiet = 1'b1;
      random_phase(115);
      quiet = 1'b0;
      set_limits(SPACE_W'($urandom_range(1, 262143)), CNT_W'($urandom_range(1, 256)));
      random_phase(115);
      set_limits(SPACE_W'(5000), CNT_W'(256));
      random_phase(115);

      wait_drain();
      $display("%0d requests and %0d responses across %0d limit settings",
               ledger.requests, ledger.replies, settings_used);
      $display("responses: %0d ok, %0d busy, %0d too large, %0d drained",
               ledger.status_seen[STATUS_OK], ledger.status_seen[STATUS_BUSY],
               ledger.status_seen[STATUS_TOO_LARGE], ledger.status_seen[STATUS_DRAINED]);
      if (ledger.errors == 0 && ledger.owed.size() == 0)
         $display("tb_command_buffer_ring_allocator: PASS");
      else
         $display("tb_command_buffer_ring_allocator: FAIL");
      $finish;
   end

endmodule
